>>> rtl/vgf_pkg.sv
package vgf_pkg;

  // Color packing: four 8-bit channels, red in the low byte.
  localparam int NUM_CHAN  = 4;
  localparam int CHAN_W    = 8;
  localparam int COLOR_W   = NUM_CHAN * CHAN_W;

  // Signed per-row quotient of one channel, range -256..255.
  localparam int STEP_W    = CHAN_W + 1;

  // Fixed widths of the output position fields and the register port.
  localparam int POS_W     = 12;
  localparam int DIM_CFG_W = 13;
  localparam int CFG_IDX_W = 8;

  localparam logic [COLOR_W-1:0]   START_COLOR_RST  = '0;
  localparam logic [COLOR_W-1:0]   END_COLOR_RST    = '1;
  localparam logic [DIM_CFG_W-1:0] FRAME_DIM_RST    = DIM_CFG_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_COLOR  = 8'd0,
    REG_END_COLOR    = 8'd1,
    REG_FRAME_WIDTH  = 8'd2,
    REG_FRAME_HEIGHT = 8'd3
  } vgf_reg_t;

  // Status from the step setup unit to the pixel generator.
  typedef struct packed {
    logic busy;
    logic load;
  } vgf_ctrl_t;

endpackage

>>> rtl/vgf_step_calc.sv
// Per-channel row step setup. After reset or a write to a mapped register, each channel
// divides |end - start| by the frame height in a restoring divider, one
// quotient bit per cycle, all four channels side by side. The result is a
// floored signed quotient, a non-negative remainder and the row-0 color.
module vgf_step_calc #(
  parameter int MAX_DIM_BITS = 12
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   start,
  input  logic [vgf_pkg::COLOR_W-1:0]                            start_color,
  input  logic [vgf_pkg::COLOR_W-1:0]                            end_color,
  input  logic [MAX_DIM_BITS:0]                                  height,
  output vgf_pkg::vgf_ctrl_t                                     ctrl,
  output logic [vgf_pkg::NUM_CHAN-1:0][vgf_pkg::STEP_W-1:0]      step_q,
  output logic [vgf_pkg::NUM_CHAN-1:0][MAX_DIM_BITS-1:0]         step_m,
  output logic [vgf_pkg::COLOR_W-1:0]                            row0_color
);

  localparam int DW = MAX_DIM_BITS + 1;
  localparam int NC = vgf_pkg::NUM_CHAN;
  localparam int CW = vgf_pkg::CHAN_W;
  localparam int QW = vgf_pkg::STEP_W;
  localparam int COLOR_W_FIX = vgf_pkg::COLOR_W;
  localparam logic [3:0] CNT_LOAD  = 4'd0;
  localparam logic [3:0] CNT_FINAL = 4'(CW + 1);
  localparam logic [3:0] CNT_DONE  = 4'(CW + 2);

  logic                       busy_r;
  logic [3:0]                 cnt_r;
  logic [NC-1:0]              neg_r;
  logic [NC-1:0][CW-1:0]      dvd_r;
  logic [NC-1:0][DW-1:0]      rem_r;
  logic [NC-1:0][QW-1:0]      q_r;
  logic [NC-1:0][DW-2:0]      m_r;
  logic [COLOR_W_FIX-1:0]     row0_r;

  logic [NC-1:0]              neg_nxt;
  logic [NC-1:0][CW-1:0]      abs_nxt;
  logic [NC-1:0]              ge;
  logic [NC-1:0][DW-1:0]      rem_step;
  logic [NC-1:0][QW-1:0]      q_fin;
  logic [NC-1:0][DW-2:0]      m_fin;
  logic [COLOR_W_FIX-1:0]     row0_fin;
  logic                       in_iter;

  // Lane logic: operand setup, one restoring step, and the signed fixup.
  always_comb begin
    logic [CW:0]   diff;
    logic [CW:0]   diff_neg;
    logic [DW:0]   trial;
    logic [DW:0]   sub;
    logic [DW-1:0] m_full;
    logic          rem_nz;
    logic [9:0]    sum;
    for (int k = 0; k < NC; k++) begin
      diff       = {1'b0, end_color[k*CW +: CW]} - {1'b0, start_color[k*CW +: CW]};
      diff_neg   = (CW+1)'(0) - diff;
      neg_nxt[k] = diff[CW];
      abs_nxt[k] = diff[CW] ? diff_neg[CW-1:0] : diff[CW-1:0];

      trial       = {rem_r[k], dvd_r[k][CW-1]};
      sub         = trial - {1'b0, height};
      ge[k]       = (trial >= {1'b0, height});
      rem_step[k] = ge[k] ? sub[DW-1:0] : trial[DW-1:0];

      rem_nz = (rem_r[k] != '0);
      m_full = height - rem_r[k];
      if (neg_r[k]) begin
        q_fin[k] = QW'(0) - {1'b0, dvd_r[k]} - QW'(rem_nz);
        m_fin[k] = rem_nz ? m_full[DW-2:0] : '0;
      end else begin
        q_fin[k] = {1'b0, dvd_r[k]};
        m_fin[k] = rem_r[k][DW-2:0];
      end

      sum = {2'b00, start_color[k*CW +: CW]} + {q_fin[k][QW-1], q_fin[k]};
      if (sum[9]) begin
        row0_fin[k*CW +: CW] = '0;
      end else if (sum[8]) begin
        row0_fin[k*CW +: CW] = '1;
      end else begin
        row0_fin[k*CW +: CW] = sum[CW-1:0];
      end
    end
  end

  assign in_iter = busy_r && (cnt_r != CNT_LOAD) && (cnt_r < CNT_FINAL);

  // Sequencer: load, one step per quotient bit, finalize, hand over.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_LOAD;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_LOAD;
    end else if (busy_r) begin
      if (cnt_r == CNT_DONE) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 4'd1;
      end
    end
  end

  // Divider lanes and result registers.
  always_ff @(posedge clk) begin
    if (busy_r && cnt_r == CNT_LOAD) begin
      neg_r <= neg_nxt;
      dvd_r <= abs_nxt;
      rem_r <= '0;
    end else if (in_iter) begin
      for (int k = 0; k < NC; k++) begin
        dvd_r[k] <= {dvd_r[k][CW-2:0], ge[k]};
        rem_r[k] <= rem_step[k];
      end
    end
    if (busy_r && cnt_r == CNT_FINAL) begin
      q_r    <= q_fin;
      m_r    <= m_fin;
      row0_r <= row0_fin;
    end
  end

  assign ctrl.busy  = busy_r;
  assign ctrl.load  = busy_r && (cnt_r == CNT_DONE);
  assign step_q     = q_r;
  assign step_m     = m_r;
  assign row0_color = row0_r;

endmodule

>>> rtl/vgf_pixel_gen.sv
// Pixel pipeline: an input register for the restart flag, then one pass of
// position and row-color stepping into the output register.
module vgf_pixel_gen #(
  parameter int MAX_DIM_BITS = 12
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  vgf_pkg::vgf_ctrl_t                                 ctrl,
  input  logic [vgf_pkg::NUM_CHAN-1:0][vgf_pkg::STEP_W-1:0]  step_q,
  input  logic [vgf_pkg::NUM_CHAN-1:0][MAX_DIM_BITS-1:0]     step_m,
  input  logic [vgf_pkg::COLOR_W-1:0]                        row0_color,
  input  logic [MAX_DIM_BITS:0]                              width,
  input  logic [MAX_DIM_BITS:0]                              height,
  input  logic                                               in_valid,
  output logic                                               in_stall,
  input  logic                                               in_restart,
  output logic                                               out_valid,
  input  logic                                               out_stall,
  output logic [vgf_pkg::COLOR_W-1:0]                        out_pixel_rgba,
  output logic [vgf_pkg::POS_W-1:0]                          out_column,
  output logic [vgf_pkg::POS_W-1:0]                          out_row,
  output logic                                               out_frame_end
);

  localparam int P  = MAX_DIM_BITS;
  localparam int NC = vgf_pkg::NUM_CHAN;
  localparam int CW = vgf_pkg::CHAN_W;
  localparam int QW = vgf_pkg::STEP_W;
  localparam int PW = vgf_pkg::POS_W;
  localparam int XW = (P > PW) ? P : PW;

  logic                          s1_valid_r;
  logic                          s1_restart_r;
  logic [P-1:0]                  col_r, col_nxt;
  logic [P-1:0]                  row_r, row_nxt;
  logic [vgf_pkg::COLOR_W-1:0]   color_r, color_nxt;
  logic [NC-1:0][P-1:0]          rem_r, rem_nxt;
  logic                          out_valid_r;
  logic [vgf_pkg::COLOR_W-1:0]   out_pixel_r;
  logic [PW-1:0]                 out_col_r;
  logic [PW-1:0]                 out_row_r;
  logic                          out_end_r;

  logic                          adv;
  logic                          fire;
  logic                          in_accept;
  logic [P-1:0]                  cur_col, cur_row;
  logic [vgf_pkg::COLOR_W-1:0]   cur_color, step_color;
  logic [NC-1:0][P-1:0]          cur_rem, step_rem;
  logic                          last_col, last_row;
  logic [XW-1:0]                 col_ext, row_ext;

  assign adv       = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && adv;
  assign in_stall  = ctrl.busy || (s1_valid_r && !adv);
  assign in_accept = in_valid && !in_stall;

  // Position and color of the pixel in flight; restart begins a new frame.
  always_comb begin
    if (s1_restart_r) begin
      cur_col   = '0;
      cur_row   = '0;
      cur_color = row0_color;
      cur_rem   = step_m;
    end else begin
      cur_col   = col_r;
      cur_row   = row_r;
      cur_color = color_r;
      cur_rem   = rem_r;
    end
    last_col = (({1'b0, cur_col} + (P+1)'(1)) >= width);
    last_row = (({1'b0, cur_row} + (P+1)'(1)) >= height);
    col_ext  = XW'(cur_col);
    row_ext  = XW'(cur_row);
  end

  // One row step per channel: add quotient and remainder, carry on wrap.
  always_comb begin
    logic [P:0]  rsum;
    logic [P:0]  rsub;
    logic        carry;
    logic [10:0] csum;
    for (int k = 0; k < NC; k++) begin
      rsum        = {1'b0, cur_rem[k]} + {1'b0, step_m[k]};
      rsub        = rsum - height;
      carry       = (rsum >= height);
      step_rem[k] = carry ? rsub[P-1:0] : rsum[P-1:0];
      csum        = {3'b000, cur_color[k*CW +: CW]} + {{2{step_q[k][QW-1]}}, step_q[k]}
                    + 11'(carry);
      if (csum[10]) begin
        step_color[k*CW +: CW] = '0;
      end else if (csum[9:8] != 2'b00) begin
        step_color[k*CW +: CW] = '1;
      end else begin
        step_color[k*CW +: CW] = csum[CW-1:0];
      end
    end
  end

  // Next frame state after the pixel in flight.
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    color_nxt = color_r;
    rem_nxt   = rem_r;
    if (ctrl.load) begin
      col_nxt   = '0;
      row_nxt   = '0;
      color_nxt = row0_color;
      rem_nxt   = step_m;
    end else if (fire) begin
      if (!last_col) begin
        col_nxt   = cur_col + P'(1);
        row_nxt   = cur_row;
        color_nxt = cur_color;
        rem_nxt   = cur_rem;
      end else if (!last_row) begin
        col_nxt   = '0;
        row_nxt   = cur_row + P'(1);
        color_nxt = step_color;
        rem_nxt   = step_rem;
      end else begin
        col_nxt   = '0;
        row_nxt   = '0;
        color_nxt = row0_color;
        rem_nxt   = step_m;
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
    color_r <= color_nxt;
    rem_r   <= rem_nxt;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || adv) begin
      s1_valid_r <= in_accept;
    end
    if (in_accept) begin
      s1_restart_r <= in_restart;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
    if (fire) begin
      out_pixel_r <= cur_color;
      out_col_r   <= col_ext[PW-1:0];
      out_row_r   <= row_ext[PW-1:0];
      out_end_r   <= last_col && last_row;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_rgba = out_pixel_r;
  assign out_column     = out_col_r;
  assign out_row        = out_row_r;
  assign out_frame_end  = out_end_r;

endmodule

>>> rtl/vertical_gradient_fill.sv
// Vertical RGBA8 gradient generator. Each accepted word on the input channel
// yields one pixel in raster order, with its column, row and a flag on the
// last pixel of the frame; every pixel of row y carries start + floor((y+1) *
// (end - start) / height) per channel, stepped exactly with per-channel
// remainders. The block takes one word per clock while in_stall is low and
// delivers each pixel through an input register and an output register.
// After reset and after every write to a mapped register the block holds
// in_stall high while four bit-serial dividers, one per channel and one
// quotient bit per cycle each, work out the per-row step; such a write also
// restarts the frame. A width or height of 0 acts as 1 and one above
// 2**MAX_DIM_BITS acts as 2**MAX_DIM_BITS. cfg_ready is always high.
module vertical_gradient_fill #(
  parameter int MAX_DIM_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vgf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vgf_pkg::COLOR_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_restart,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [vgf_pkg::COLOR_W-1:0]        out_pixel_rgba,
  output logic [vgf_pkg::POS_W-1:0]          out_column,
  output logic [vgf_pkg::POS_W-1:0]          out_row,
  output logic                               out_frame_end
);

  localparam int P  = MAX_DIM_BITS;
  localparam int DC = vgf_pkg::DIM_CFG_W;
  localparam int EW = (P + 1 > DC) ? P + 1 : DC;

  logic [vgf_pkg::COLOR_W-1:0]  start_color_r;
  logic [vgf_pkg::COLOR_W-1:0]  end_color_r;
  logic [DC-1:0]                frame_width_r;
  logic [DC-1:0]                frame_height_r;
  logic                         cfg_hit;
  logic                         cfg_wr;
  logic [P:0]                   width_eff;
  logic [P:0]                   height_eff;
  vgf_pkg::vgf_ctrl_t           ctrl;
  logic [vgf_pkg::NUM_CHAN-1:0][vgf_pkg::STEP_W-1:0] step_q;
  logic [vgf_pkg::NUM_CHAN-1:0][P-1:0]               step_m;
  logic [vgf_pkg::COLOR_W-1:0]  row0_color;

  // Clamp a programmed dimension to 1..2**MAX_DIM_BITS.
  function automatic logic [P:0] eff_dim(input logic [DC-1:0] v);
    logic [EW-1:0] ve;
    logic [EW-1:0] lim;
    logic [EW-1:0] res;
    ve  = EW'(v);
    lim = EW'(1) << P;
    if (ve == '0) begin
      res = EW'(1);
    end else if (ve > lim) begin
      res = lim;
    end else begin
      res = ve;
    end
    return res[P:0];
  endfunction

  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign width_eff  = eff_dim(frame_width_r);
  assign height_eff = eff_dim(frame_height_r);

  // Register decode.
  always_comb begin
    case (cfg_index)
      vgf_pkg::REG_START_COLOR,
      vgf_pkg::REG_END_COLOR,
      vgf_pkg::REG_FRAME_WIDTH,
      vgf_pkg::REG_FRAME_HEIGHT: cfg_hit = 1'b1;
      default:                   cfg_hit = 1'b0;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_color_r  <= vgf_pkg::START_COLOR_RST;
      end_color_r    <= vgf_pkg::END_COLOR_RST;
      frame_width_r  <= vgf_pkg::FRAME_DIM_RST;
      frame_height_r <= vgf_pkg::FRAME_DIM_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        vgf_pkg::REG_START_COLOR:  start_color_r  <= cfg_wdata;
        vgf_pkg::REG_END_COLOR:    end_color_r    <= cfg_wdata;
        vgf_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[DC-1:0];
        vgf_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[DC-1:0];
        default: ;
      endcase
    end
  end

  vgf_step_calc #(
    .MAX_DIM_BITS (MAX_DIM_BITS)
  ) u_step_calc (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (cfg_wr && cfg_hit),
    .start_color (start_color_r),
    .end_color   (end_color_r),
    .height      (height_eff),
    .ctrl        (ctrl),
    .step_q      (step_q),
    .step_m      (step_m),
    .row0_color  (row0_color)
  );

  vgf_pixel_gen #(
    .MAX_DIM_BITS (MAX_DIM_BITS)
  ) u_pixel_gen (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .step_q         (step_q),
    .step_m         (step_m),
    .row0_color     (row0_color),
    .width          (width_eff),
    .height         (height_eff),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_rgba (out_pixel_rgba),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_frame_end  (out_frame_end)
  );

endmodule

>>> tb/sv/vertical_gradient_fill_tb.sv
module vertical_gradient_fill_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_BITS    = 12;
  localparam int ITEM_TARGET = 950;
  localparam int HOLD_PHASE  = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 10;
  localparam int STUCK_LIMIT = 4000;

  // Local copies of the package widths used in size casts.
  localparam int IDX_W    = vgf_pkg::CFG_IDX_W;
  localparam int DIM_W    = vgf_pkg::DIM_CFG_W;
  localparam int POS_BITS = vgf_pkg::POS_W;

  // Register indexes past the last mapped register; writes there are ignored.
  localparam logic [IDX_W-1:0] REG_UNMAPPED_LO = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_UNMAPPED_HI = '1;

  typedef struct packed {
    logic [vgf_pkg::COLOR_W-1:0] rgba;
    logic [POS_BITS-1:0]         col;
    logic [POS_BITS-1:0]         row;
    logic                        frame_end;
  } pixel_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [IDX_W-1:0]            cfg_index = '0;
  logic [vgf_pkg::COLOR_W-1:0] cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_restart = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [vgf_pkg::COLOR_W-1:0] out_pixel_rgba;
  logic [POS_BITS-1:0]         out_column;
  logic [POS_BITS-1:0]         out_row;
  logic                        out_frame_end;

  vertical_gradient_fill #(
    .MAX_DIM_BITS(DIM_BITS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_rgba (out_pixel_rgba),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_frame_end  (out_frame_end)
  );

  // Gradient generator state, kept in step with the block.
  logic [vgf_pkg::COLOR_W-1:0] cfg_start_rgba;
  logic [vgf_pkg::COLOR_W-1:0] cfg_end_rgba;
  logic [DIM_W-1:0]            cfg_width;
  logic [DIM_W-1:0]            cfg_height;
  int                          next_col;
  int                          next_row;
  logic [vgf_pkg::COLOR_W-1:0] cur_row_rgba;
  int                          chan_frac [vgf_pkg::NUM_CHAN];

  // Restart bits waiting to be sent, and pixels the block still owes us.
  logic   restart_fifo [$];
  pixel_t pixel_fifo [$];

  int items_queued = 0;
  int items_taken = 0;
  int pixels_checked = 0;
  int frame_ends = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int phase_no = 0;

  int          gap_left = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_span = 0;
  int          hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int          stuck = 0;

  // A programmed dimension of 0 means 1; anything past 2**DIM_BITS saturates.
  function automatic int span_of(logic [DIM_W-1:0] v);
    int limit;
    limit = 1 << DIM_BITS;
    if (v == 0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  // Advance every channel by one row: exact floor step plus a carried remainder.
  function automatic void row_step();
    int h, lo, hi, lvl, diff, q, frac;
    logic [vgf_pkg::COLOR_W-1:0] rgba;
    h = span_of(cfg_height);
    rgba = '0;
    for (int k = 0; k < vgf_pkg::NUM_CHAN; k++) begin
      lo = int'(cfg_start_rgba[vgf_pkg::CHAN_W*k +: vgf_pkg::CHAN_W]);
      hi = int'(cfg_end_rgba[vgf_pkg::CHAN_W*k +: vgf_pkg::CHAN_W]);
      lvl = int'(cur_row_rgba[vgf_pkg::CHAN_W*k +: vgf_pkg::CHAN_W]);
      diff = hi - lo;
      // Division truncates toward zero; pull falling channels down to the floor.
      q = diff / h;
      frac = diff % h;
      if (frac < 0) begin
        q -= 1;
        frac += h;
      end
      lvl += q;
      frac += chan_frac[k];
      if (frac >= h) begin
        frac -= h;
        lvl++;
      end
      if (lvl < 0) lvl = 0;
      else if (lvl > (1 << vgf_pkg::CHAN_W) - 1) lvl = (1 << vgf_pkg::CHAN_W) - 1;
      chan_frac[k] = frac;
      rgba[vgf_pkg::CHAN_W*k +: vgf_pkg::CHAN_W] = lvl[vgf_pkg::CHAN_W-1:0];
    end
    cur_row_rgba = rgba;
  endfunction

  function automatic void frame_restart();
    next_col = 0;
    next_row = 0;
    cur_row_rgba = cfg_start_rgba;
    for (int k = 0; k < vgf_pkg::NUM_CHAN; k++) chan_frac[k] = 0;
    row_step();
  endfunction

  function automatic void grad_reset();
    cfg_start_rgba = vgf_pkg::START_COLOR_RST;
    cfg_end_rgba = vgf_pkg::END_COLOR_RST;
    cfg_width = vgf_pkg::FRAME_DIM_RST;
    cfg_height = vgf_pkg::FRAME_DIM_RST;
    frame_restart();
  endfunction

  // Any mapped register write restarts the frame; unmapped indexes change nothing.
  function automatic void grad_write(logic [IDX_W-1:0] idx,
                                     logic [vgf_pkg::COLOR_W-1:0] data);
    case (idx)
      vgf_pkg::REG_START_COLOR:  cfg_start_rgba = data;
      vgf_pkg::REG_END_COLOR:    cfg_end_rgba = data;
      vgf_pkg::REG_FRAME_WIDTH:  cfg_width = data[DIM_W-1:0];
      vgf_pkg::REG_FRAME_HEIGHT: cfg_height = data[DIM_W-1:0];
      default:                   return;
    endcase
    frame_restart();
  endfunction

  // Pixel produced by one accepted word, in raster order with frame wrap.
  function automatic pixel_t gen_pixel(logic restart);
    pixel_t px;
    int w, h;
    logic last_col, last_row;
    w = span_of(cfg_width);
    h = span_of(cfg_height);
    if (restart) frame_restart();
    last_col = (next_col + 1 >= w);
    last_row = (next_row + 1 >= h);
    px.rgba = cur_row_rgba;
    px.col = POS_BITS'(next_col);
    px.row = POS_BITS'(next_row);
    px.frame_end = last_col && last_row;
    if (!last_col) begin
      next_col++;
    end else if (!last_row) begin
      next_col = 0;
      next_row++;
      row_step();
    end else begin
      frame_restart();
    end
    return px;
  endfunction

  function automatic void flag_pixel(string why, pixel_t want, pixel_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected rgba %h col %0d row %0d end %0b, ",
               $time, why, want.rgba, want.col, want.row, want.frame_end,
               "got rgba %h col %0d row %0d end %0b",
               got.rgba, got.col, got.row, got.frame_end);
  endfunction

  function automatic logic [vgf_pkg::COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly small frames; now and then a zero, the maximum, or a saturating value.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return DIM_W'(4096);
      2:       return '1;
      3:       return DIM_W'($urandom_range(4097, 8191));
      default: return DIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic void add_item(logic restart);
    restart_fifo.push_back(restart);
    items_queued++;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [vgf_pkg::COLOR_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    grad_write(idx, data);
    reg_writes++;
  endtask

  // Block is idle once every word is sent and every pixel has come back.
  task automatic wait_drained();
    do @(posedge clk); while (restart_fifo.size() != 0 || in_valid || pixel_fifo.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Sender: bursts of words with random gaps; a stalled word is held as is.
  always @(posedge clk) begin
    logic take;
    logic nxt_valid;
    logic nxt_restart;
    take = rst_n && in_valid && !in_stall;
    if (take) begin
      pixel_fifo.push_back(gen_pixel(in_restart));
      void'(restart_fifo.pop_front());
      items_taken++;
    end
    nxt_valid = in_valid && !take;
    nxt_restart = in_restart;
    if (!nxt_valid) begin
      nxt_restart = $urandom_range(0, 1);
      if (gap_left > 0) begin
        gap_left--;
      end else if (rst_n && restart_fifo.size() != 0) begin
        nxt_valid = 1'b1;
        nxt_restart = restart_fifo[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_valid <= nxt_valid;
    in_restart <= nxt_restart;
  end

  // Long receiver hold-off, started by a toggle of hold_req.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Receiver: check each accepted pixel and drive the stall pattern.
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    logic nxt_stall;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_pixel_rgba, out_column, out_row, out_frame_end};
      pixels_checked++;
      if (got.frame_end) frame_ends++;
      if (pixel_fifo.size() == 0) begin
        flag_pixel("pixel with no word pending", '0, got);
      end else begin
        want = pixel_fifo.pop_front();
        if (got.rgba !== want.rgba || got.col !== want.col || got.row !== want.row ||
            got.frame_end !== want.frame_end)
          flag_pixel("pixel mismatch", want, got);
      end
    end
    // The stall pattern picks a new mode at random whenever its span runs out.
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(4, 60);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      STALL_NONE:  nxt_stall = 1'b0;
      STALL_LIGHT: nxt_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: nxt_stall = ($urandom_range(0, 3) != 0);
      default:     nxt_stall = !out_stall;
    endcase
    if (hold_left != 0) nxt_stall = 1'b1;
    out_stall <= nxt_stall;
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d pixels outstanding",
               stuck, pixel_fifo.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [3:0] wr_mask;
    logic       odd_write;
    int         n;
    grad_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: every pixel is a one-pixel frame of the end color.
    @(negedge clk);
    add_item(1'b0);
    add_item(1'b1);
    add_item(1'b0);
    wait_drained();

    // Channels rising and falling, zero width, frames wrapping, a mid-frame restart.
    write_reg(vgf_pkg::REG_START_COLOR, 32'h00FF10F0);
    write_reg(vgf_pkg::REG_END_COLOR, 32'hFF00F010);
    write_reg(vgf_pkg::REG_FRAME_WIDTH, 32'h0);
    write_reg(vgf_pkg::REG_FRAME_HEIGHT, 32'h5);
    @(negedge clk);
    repeat (6) add_item(1'b0);
    add_item(1'b1);
    repeat (2) add_item(1'b0);
    wait_drained();

    // Unmapped indexes must leave the stream where it was.
    write_reg(REG_UNMAPPED_LO, 32'h12345678);
    write_reg(REG_UNMAPPED_HI, 32'hFFFFFFFF);
    @(negedge clk);
    repeat (2) add_item(1'b0);
    wait_drained();

    // Junk above the dimension field, and a height that saturates.
    write_reg(vgf_pkg::REG_FRAME_WIDTH, 32'hABCD0003);
    write_reg(vgf_pkg::REG_FRAME_HEIGHT, 32'h00001FFF);
    @(negedge clk);
    add_item(1'b1);
    repeat (4) add_item(1'b0);
    wait_drained();

    // Full-scale descent with a width just past the maximum.
    write_reg(vgf_pkg::REG_START_COLOR, '1);
    write_reg(vgf_pkg::REG_END_COLOR, '0);
    write_reg(vgf_pkg::REG_FRAME_WIDTH, 32'd4097);
    write_reg(vgf_pkg::REG_FRAME_HEIGHT, 32'd1);
    @(negedge clk);
    repeat (3) add_item(1'b0);

    // Random phases: some register writes while idle, then a run of words.
    while (items_queued < ITEM_TARGET) begin
      phase_no++;
      wr_mask = ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
      odd_write = ($urandom_range(0, 9) == 0);
      if (wr_mask != 0 || odd_write) wait_drained();
      if (wr_mask[0]) write_reg(vgf_pkg::REG_START_COLOR, pick_color());
      if (wr_mask[1])
        write_reg(vgf_pkg::REG_END_COLOR,
                  ($urandom_range(0, 7) == 0) ? cfg_start_rgba : pick_color());
      if (wr_mask[2]) write_reg(vgf_pkg::REG_FRAME_WIDTH, {19'($urandom), pick_dim()});
      if (wr_mask[3]) write_reg(vgf_pkg::REG_FRAME_HEIGHT, {19'($urandom), pick_dim()});
      if (odd_write)
        write_reg(IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)), $urandom);
      n = (phase_no == HOLD_PHASE) ? 200 : $urandom_range(8, 60);
      @(negedge clk);
      repeat (n) add_item($urandom_range(0, 19) == 0);
      // One long receiver hold while the sender keeps offering words.
      if (phase_no == HOLD_PHASE) hold_req <= ~hold_req;
    end

    wait_drained();
    if (pixel_fifo.size() != 0) mismatches += pixel_fifo.size();
    $display("Sent %0d words over %0d phases and %0d register writes.",
             items_taken, phase_no, reg_writes);
    $display("Checked %0d pixels, %0d of them frame ends.", pixels_checked, frame_ends);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> vertical_gradient_fill.f
rtl/vgf_pkg.sv
rtl/vgf_step_calc.sv
rtl/vgf_pixel_gen.sv
rtl/vertical_gradient_fill.sv
tb/sv/vertical_gradient_fill_tb.sv
